// ===== rtl/rtpap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpap_pkg: shared types and constants of the RTP audio packetizer
// Beat structs, configuration struct, queue entry and header byte codes.
// ----------------------------------------------------------------------------
package rtpap_pkg;

   // input item commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // configuration register indexes
   localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd0;
   localparam logic [1:0] REG_STREAM_SSRC  = 2'd1;
   localparam logic [1:0] REG_TCP_IL       = 2'd2;

   // header constants
   localparam int unsigned  RTP_HDR_LEN = 12;
   localparam int unsigned  IL_HDR_LEN  = 4;
   localparam logic [31:0]  REBASE_TIME = 32'd1600;
   localparam logic [7:0]   IL_MARK     = 8'h24;
   localparam logic [7:0]   IL_CHANNEL  = 8'h02;
   localparam logic [7:0]   RTP_VER     = 8'h80;
   localparam logic [15:0]  RTP_LEN0    = 16'(RTP_HDR_LEN);

   // byte positions of the emitted packet stream
   localparam logic [4:0] POS_IL_MARK  = 5'd0;
   localparam logic [4:0] POS_IL_CHAN  = 5'd1;
   localparam logic [4:0] POS_IL_LENH  = 5'd2;
   localparam logic [4:0] POS_IL_LENL  = 5'd3;
   localparam logic [4:0] POS_RTP_VER  = 5'd4;
   localparam logic [4:0] POS_RTP_PT   = 5'd5;
   localparam logic [4:0] POS_SEQ_H    = 5'd6;
   localparam logic [4:0] POS_SEQ_L    = 5'd7;
   localparam logic [4:0] POS_TS_3     = 5'd8;
   localparam logic [4:0] POS_TS_2     = 5'd9;
   localparam logic [4:0] POS_TS_1     = 5'd10;
   localparam logic [4:0] POS_TS_0     = 5'd11;
   localparam logic [4:0] POS_SSRC_3   = 5'd12;
   localparam logic [4:0] POS_SSRC_2   = 5'd13;
   localparam logic [4:0] POS_SSRC_1   = 5'd14;
   localparam logic [4:0] POS_SSRC_0   = 5'd15;
   localparam logic [4:0] POS_DATA     = 5'd16;

   typedef struct packed {
      logic        command;
      logic [15:0] frame_length;
      logic [31:0] capture_time;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  payload_type;
      logic [31:0] stream_ssrc;
      logic        tcp_interleaved;
   } cfg_type;

   // one classified item handed from front to back
   typedef struct packed {
      logic        has_hdr;
      logic        has_byte;
      logic        marker;
      logic        byte_end;
      logic [15:0] seq;
      logic [31:0] stime;
      logic [15:0] rtp_len;
      logic [7:0]  data_byte;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/rtpap_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpap_front: item classifier
// Tracks frame state, rebases timestamps and turns each item into a job.
// ----------------------------------------------------------------------------
module rtpap_front import rtpap_pkg::*; #(
   parameter int MAX_PACKET_BYTES   = 2048,
   parameter int FRAME_HEADER_BYTES = 4
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   input  cfg_type    cfg,
   output logic       push_valid,
   input  wire        push_ready,
   output entry_type  push_data
);

   localparam int SKIP_W = $clog2(FRAME_HEADER_BYTES + 2);
   localparam logic [15:0] FHB16      = 16'(FRAME_HEADER_BYTES);
   localparam logic [15:0] ROOM_IL    = 16'(MAX_PACKET_BYTES - RTP_HDR_LEN - IL_HDR_LEN);
   localparam logic [15:0] ROOM_PLAIN = 16'(MAX_PACKET_BYTES - RTP_HDR_LEN);

   logic [15:0]       seq_ff, seq_in;
   logic [31:0]       prev_cap_ff, prev_cap_in;
   logic [31:0]       prev_st_ff, prev_st_in;
   logic [31:0]       cur_st_ff, cur_st_in;
   logic [15:0]       remain_ff, remain_in;
   logic [15:0]       fill_ff, fill_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;

   logic        accept;
   logic [31:0] pts;
   logic [15:0] room, len, fill_cur;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // rebase on first frame or when time runs backward
      if (prev_cap_ff == '0 || req_data.capture_time < prev_cap_ff) begin
         pts = REBASE_TIME;
      end else begin
         pts = prev_st_ff + (req_data.capture_time - prev_cap_ff);
      end
      room     = cfg.tcp_interleaved ? ROOM_IL : ROOM_PLAIN;
      len      = (remain_ff > room) ? room : remain_ff;
      fill_cur = (fill_ff == '0) ? len : fill_ff;
   end

   always_comb begin
      seq_in      = seq_ff;
      prev_cap_in = prev_cap_ff;
      prev_st_in  = prev_st_ff;
      cur_st_in   = cur_st_ff;
      remain_in   = remain_ff;
      fill_in     = fill_ff;
      skip_in     = skip_ff;
      push_valid  = 1'b0;
      push_data.has_hdr   = 1'b0;
      push_data.has_byte  = 1'b0;
      push_data.marker    = 1'b0;
      push_data.byte_end  = 1'b0;
      push_data.seq       = seq_ff + 16'd1;
      push_data.stime     = cur_st_ff;
      push_data.rtp_len   = len + RTP_LEN0;
      push_data.data_byte = req_data.data_byte;
      if (accept) begin
         unique case (req_data.command)
            CMD_START: begin
               prev_cap_in     = req_data.capture_time;
               prev_st_in      = pts;
               cur_st_in       = pts;
               fill_in         = '0;
               push_data.stime = pts;
               if (req_data.frame_length > FHB16) begin
                  skip_in   = SKIP_W'(FRAME_HEADER_BYTES);
                  remain_in = req_data.frame_length - FHB16;
               end else begin
                  // short frame: one header-only packet
                  skip_in           = req_data.frame_length[SKIP_W-1:0];
                  remain_in         = '0;
                  seq_in            = seq_ff + 16'd1;
                  push_valid        = 1'b1;
                  push_data.has_hdr = 1'b1;
                  push_data.marker  = 1'b1;
                  push_data.rtp_len = RTP_LEN0;
               end
            end
            CMD_DATA: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - SKIP_W'(1);
               end else if (remain_ff != '0) begin
                  push_valid         = 1'b1;
                  push_data.has_byte = 1'b1;
                  if (fill_ff == '0) begin
                     seq_in            = seq_ff + 16'd1;
                     push_data.has_hdr = 1'b1;
                     push_data.marker  = (remain_ff <= room);
                  end
                  fill_in            = fill_cur - 16'd1;
                  remain_in          = remain_ff - 16'd1;
                  push_data.byte_end = (fill_cur == 16'd1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= '0;
         prev_cap_ff <= '0;
         prev_st_ff  <= '0;
         cur_st_ff   <= '0;
         remain_ff   <= '0;
         fill_ff     <= '0;
         skip_ff     <= '0;
      end else begin
         seq_ff      <= seq_in;
         prev_cap_ff <= prev_cap_in;
         prev_st_ff  <= prev_st_in;
         cur_st_ff   <= cur_st_in;
         remain_ff   <= remain_in;
         fill_ff     <= fill_in;
         skip_ff     <= skip_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rtpap_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpap_queue: job queue
// Short first-in first-out buffer between classifier and emitter.
// ----------------------------------------------------------------------------
module rtpap_queue import rtpap_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        push_valid,
   output logic       push_ready,
   input  entry_type  push_data,
   output logic       pop_valid,
   input  wire        pop_ready,
   output entry_type  pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign push_ready = (cnt_ff < CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rtpap_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpap_back: byte emitter
// Walks each job through header positions and payload into the output register.
// ----------------------------------------------------------------------------
module rtpap_back import rtpap_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        pop_valid,
   output logic       pop_ready,
   input  entry_type  pop_data,
   input  cfg_type    cfg,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output rsp_type    rsp_data
);

   logic [4:0] pos_ff, pos_in;
   logic       busy_ff, busy_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       load;
   logic [4:0] pos, first_pos, last_pos;
   logic [7:0] hdr_byte;
   logic       at_last;

   assign load = pop_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (!pop_data.has_hdr) begin
         first_pos = POS_DATA;
      end else if (cfg.tcp_interleaved) begin
         first_pos = POS_IL_MARK;
      end else begin
         first_pos = POS_RTP_VER;
      end
      last_pos = pop_data.has_byte ? POS_DATA : POS_SSRC_0;
      pos      = busy_ff ? pos_ff : first_pos;
      at_last  = (pos == last_pos);
   end

   always_comb begin
      unique case (pos)
         POS_IL_MARK: hdr_byte = IL_MARK;
         POS_IL_CHAN: hdr_byte = IL_CHANNEL;
         POS_IL_LENH: hdr_byte = pop_data.rtp_len[15:8];
         POS_IL_LENL: hdr_byte = pop_data.rtp_len[7:0];
         POS_RTP_VER: hdr_byte = RTP_VER;
         POS_RTP_PT:  hdr_byte = {pop_data.marker, cfg.payload_type};
         POS_SEQ_H:   hdr_byte = pop_data.seq[15:8];
         POS_SEQ_L:   hdr_byte = pop_data.seq[7:0];
         POS_TS_3:    hdr_byte = pop_data.stime[31:24];
         POS_TS_2:    hdr_byte = pop_data.stime[23:16];
         POS_TS_1:    hdr_byte = pop_data.stime[15:8];
         POS_TS_0:    hdr_byte = pop_data.stime[7:0];
         POS_SSRC_3:  hdr_byte = cfg.stream_ssrc[31:24];
         POS_SSRC_2:  hdr_byte = cfg.stream_ssrc[23:16];
         POS_SSRC_1:  hdr_byte = cfg.stream_ssrc[15:8];
         POS_SSRC_0:  hdr_byte = cfg.stream_ssrc[7:0];
         default:     hdr_byte = pop_data.data_byte;
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      busy_in      = busy_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_ready    = 1'b0;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = hdr_byte;
         rsp_in.last_of_run = at_last;
         rsp_in.packet_end  = at_last &&
                              (pop_data.has_byte ? pop_data.byte_end : 1'b1);
         if (at_last) begin
            pop_ready = 1'b1;
            busy_in   = 1'b0;
         end else begin
            pos_in  = pos + 5'd1;
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/rtp_audio_packetizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_audio_packetizer: RTP audio packetizer with interleaved framing
// Strips frame headers, rebases timestamps and emits RTP packets byte-wise.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports        | beat
//   --------+-----------+--------------+------------------------------------
//   req     | in        | valid/ready  | start (length, time) or one byte
//   rsp     | out       | valid/ready  | one packet stream byte + end flags
//   csr     | in/out    | APB-style    | payload type, SSRC, interleave
//
// Payload bytes inside an open packet stream at one beat per clock while
// rsp_ready stays high. A packet that opens emits 16 header beats (12
// without interleave) ahead of its first payload byte; the emitter sets
// that figure, and the two-entry job queue absorbs input until it fills,
// then holds req_ready low. Dropped frame-header bytes give no output.
// Reset (synchronous, active high) clears frame state, sequence number,
// timestamps, the queue and the output valid flag; config resets to
// payload type 0, SSRC 0, interleave on. rsp stalls back up through the
// queue into req_ready only.
//
module rtp_audio_packetizer import rtpap_pkg::*; #(
   parameter int MAX_PACKET_BYTES   = 2048,
   parameter int FRAME_HEADER_BYTES = 4,
   parameter int QUEUE_DEPTH        = 2
) (
   input  wire         clock,
   input  wire         reset,
   // input beats
   input  wire         req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // result beats
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output rsp_type     rsp_data,
   // configuration port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [3:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type     cfg_ff, cfg_in;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   logic        push_valid, push_ready;
   entry_type   push_data;
   logic        pop_valid, pop_ready;
   entry_type   pop_data;

   // configuration registers: write on the access phase
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_PAYLOAD_TYPE: cfg_in.payload_type    = csr_pwdata[6:0];
            REG_STREAM_SSRC:  cfg_in.stream_ssrc     = csr_pwdata;
            REG_TCP_IL:       cfg_in.tcp_interleaved = csr_pwdata[0];
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PAYLOAD_TYPE: csr_prdata = {25'd0, cfg_ff.payload_type};
         REG_STREAM_SSRC:  csr_prdata = cfg_ff.stream_ssrc;
         REG_TCP_IL:       csr_prdata = {31'd0, cfg_ff.tcp_interleaved};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.payload_type    <= '0;
         cfg_ff.stream_ssrc     <= '0;
         cfg_ff.tcp_interleaved <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify items, advance frame state
   rtpap_front #(
      .MAX_PACKET_BYTES   (MAX_PACKET_BYTES),
      .FRAME_HEADER_BYTES (FRAME_HEADER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // hold jobs between the two sides
   rtpap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // serialize each job into packet bytes
   rtpap_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/rtpap_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpap_checker: port-level checks
// Watches the packetizer ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module rtpap_checker import rtpap_pkg::*; (
   input wire     clock,
   input wire     reset,
   input wire     rsp_valid,
   input wire     rsp_ready,
   input rsp_type rsp_data,
   input wire     csr_pready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // every packet closes on the final beat of its item
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_end |-> rsp_data.last_of_run)
      else $error("packet end not on last beat of item");

   // the configuration port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr pready low");

endmodule

bind rtp_audio_packetizer rtpap_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);
`default_nettype wire

// ===== verif/rtp_audio_packetizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_audio_packetizer_test: self-checking bench for the RTP audio packetizer
// Drives frames (start beat plus frame bytes) through the req channel, keeps
// a cycle-free shadow of the packetizer that predicts every packet stream
// byte, and compares each rsp beat in order. Covers the short-frame,
// extra-byte, abandoned-frame and orphan-byte cases, register settings at
// their extremes, random idling on both channels and a long output stall
// that backs up into req_ready.
// ----------------------------------------------------------------------------
module rtp_audio_packetizer_test;
   import rtpap_pkg::*;

   localparam int MAX_PKT       = 2048;
   localparam int FRM_HDR       = 4;
   localparam int SETTLE_CYCLES = 48;      // covers the job queue plus a full header
   localparam int TAIL_CYCLES   = 64;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PRINT_CAP     = 40;

   // clock, reset and block ports; every input known from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // idling control for the sender and the receiver
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int rx_hold_left = 0;

   int cycle_count = 0;
   int err_count   = 0;

   // shadow of the packetizer: registers and frame state
   cfg_type     csr_shadow;
   logic [15:0] seq_num;
   logic [31:0] prev_cap;
   logic [31:0] prev_stime;
   logic [31:0] cur_stime;
   logic [15:0] payload_left;
   logic [15:0] fill_left;
   logic [7:0]  skip_left;

   // packet stream bytes still due on rsp, oldest first
   rsp_type     bytes_due[$];
   rsp_type     byte_held;
   bit          byte_held_ok = 1'b0;

   logic [31:0] gen_cap = '0;  // capture time of the generated frames

   rtp_audio_packetizer #(
      .MAX_PACKET_BYTES   (MAX_PKT),
      .FRAME_HEADER_BYTES (FRM_HDR)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // run guard: end the run if the stream never drains
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[rtp_audio_packetizer] ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Mismatch reporting: one line per mismatch, printing capped, all counted
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      if (err_count < PRINT_CAP)
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      err_count = err_count + 1;
   endtask

   // -------------------------------------------------------------------------
   // Shadow packetizer
   // -------------------------------------------------------------------------
   // Hold each byte back by one so the last byte of a beat's run can be
   // flagged once the run is complete.
   task automatic put_byte(input logic [7:0] value, input logic at_end);
      if (byte_held_ok)
         bytes_due.push_back(byte_held);
      byte_held.out_byte    = value;
      byte_held.packet_end  = at_end;
      byte_held.last_of_run = 1'b0;
      byte_held_ok          = 1'b1;
   endtask

   // Queue the interleave header (if on) and the RTP header of a new packet.
   task automatic open_packet(input logic [15:0] len, input logic marker,
                              input logic end_now);
      logic [15:0] rtp_len;
      rtp_len = len + RTP_LEN0;
      seq_num = seq_num + 16'd1;
      if (csr_shadow.tcp_interleaved) begin
         put_byte(IL_MARK, 1'b0);
         put_byte(IL_CHANNEL, 1'b0);
         put_byte(rtp_len[15:8], 1'b0);
         put_byte(rtp_len[7:0], 1'b0);
      end
      put_byte(RTP_VER, 1'b0);
      put_byte({marker, csr_shadow.payload_type}, 1'b0);
      put_byte(seq_num[15:8], 1'b0);
      put_byte(seq_num[7:0], 1'b0);
      put_byte(cur_stime[31:24], 1'b0);
      put_byte(cur_stime[23:16], 1'b0);
      put_byte(cur_stime[15:8], 1'b0);
      put_byte(cur_stime[7:0], 1'b0);
      put_byte(csr_shadow.stream_ssrc[31:24], 1'b0);
      put_byte(csr_shadow.stream_ssrc[23:16], 1'b0);
      put_byte(csr_shadow.stream_ssrc[15:8], 1'b0);
      put_byte(csr_shadow.stream_ssrc[7:0], end_now);
   endtask

   // Advance the shadow by one accepted req beat and queue the bytes it causes.
   task automatic packetize_beat(input req_type b);
      logic [31:0] stime;
      int          room;
      int          len;
      logic        last;
      if (b.command == CMD_START) begin
         // rebase on the first frame or when capture time goes backward
         if (prev_cap == 32'd0 || b.capture_time < prev_cap)
            stime = REBASE_TIME;
         else
            stime = prev_stime + (b.capture_time - prev_cap);
         prev_cap   = b.capture_time;
         prev_stime = stime;
         cur_stime  = stime;
         fill_left  = '0;
         if (b.frame_length > FRM_HDR) begin
            skip_left    = 8'(FRM_HDR);
            payload_left = b.frame_length - 16'(FRM_HDR);
         end else begin
            // short frame: no payload, one header-only packet
            skip_left    = b.frame_length[7:0];
            payload_left = '0;
            open_packet(16'd0, 1'b1, 1'b1);
         end
      end else if (skip_left > 0) begin
         skip_left = skip_left - 8'd1;
      end else if (payload_left > 0) begin
         if (fill_left == 0) begin
            room = MAX_PKT - RTP_HDR_LEN - (csr_shadow.tcp_interleaved ? IL_HDR_LEN : 0);
            len  = payload_left;
            last = 1'b1;
            if (len > room) begin
               len  = room;
               last = 1'b0;
            end
            fill_left = 16'(len);
            open_packet(16'(len), last, 1'b0);
         end
         fill_left    = fill_left - 16'd1;
         payload_left = payload_left - 16'd1;
         put_byte(b.data_byte, fill_left == 0);
      end
      if (byte_held_ok) begin
         byte_held.last_of_run = 1'b1;
         bytes_due.push_back(byte_held);
         byte_held_ok = 1'b0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Result checking: compare every accepted rsp beat with the oldest byte due
   // -------------------------------------------------------------------------
   rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (bytes_due.size() == 0) begin
            report_mismatch("beat with nothing due, out_byte", rsp_data.out_byte, 0);
         end else begin
            want = bytes_due.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
            if (rsp_data.packet_end !== want.packet_end)
               report_mismatch("packet_end", rsp_data.packet_end, want.packet_end);
            if (rsp_data.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", rsp_data.last_of_run, want.last_of_run);
         end
      end
   end

   // Receiver: hold off for a counted stretch when asked, else idle at random.
   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left = rx_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------
   function automatic req_type start_beat(input logic [15:0] flen, input logic [31:0] cap);
      req_type b;
      b.command      = CMD_START;
      b.frame_length = flen;
      b.capture_time = cap;
      b.data_byte    = 8'($urandom);   // ignored on a start
      return b;
   endfunction

   function automatic req_type data_beat(input logic [7:0] value);
      req_type b;
      b.command      = CMD_DATA;
      b.frame_length = 16'($urandom);  // ignored on a data beat
      b.capture_time = $urandom;
      b.data_byte    = value;
      return b;
   endfunction

   // Offer one beat, idling cycle by cycle at random first, and hold it until
   // taken.
   task automatic send_beat(input req_type b);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (!req_ready);
      packetize_beat(b);
   endtask

   // Drop valid, then wait until every byte due has come out.
   task automatic wait_stream_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the shadow follows on the edge.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_PAYLOAD_TYPE: csr_shadow.payload_type    = value[6:0];
         REG_STREAM_SSRC:  csr_shadow.stream_ssrc     = value;
         REG_TCP_IL:       csr_shadow.tcp_interleaved = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Reprogram only once the block has gone quiet.
   task automatic set_config(input logic [6:0] pt, input logic [31:0] ssrc, input logic il);
      wait_stream_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(REG_PAYLOAD_TYPE, {25'd0, pt});
      write_reg(REG_STREAM_SSRC, ssrc);
      write_reg(REG_TCP_IL, {31'd0, il});
   endtask

   // Mostly well-formed frames with random content; some short, truncated,
   // over-long or huge-and-abandoned frames and stray bytes mixed in.
   task automatic send_random_frames(input int beats);
      int          sent;
      int          pick;
      int          flen;
      int          nbytes;
      logic [31:0] cap;
      sent = 0;
      while (sent < beats) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_beat(data_beat(8'($urandom)));   // stray byte, not counted
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
               flen = $urandom_range(0, FRM_HDR);
            else if (pick < 18)
               flen = $urandom_range(0, 65535);
            else
               flen = $urandom_range(FRM_HDR + 1, FRM_HDR + 40);

            pick = $urandom_range(0, 99);
            if (pick < 65)
               gen_cap = gen_cap + 32'($urandom_range(0, 3000));
            else if (pick < 77)
               gen_cap = gen_cap - 32'($urandom_range(1, 3000));   // backward
            else if (pick < 82)
               gen_cap = '0;
            else if (pick < 90)
               gen_cap = gen_cap;                                 // zero delta
            else
               gen_cap = $urandom;
            cap = gen_cap;

            pick = $urandom_range(0, 99);
            if (flen > FRM_HDR + 40)
               nbytes = $urandom_range(0, 30);                    // abandon early
            else if (pick < 80)
               nbytes = flen;
            else if (pick < 90)
               nbytes = (flen > 0) ? $urandom_range(0, flen - 1) : 0;
            else
               nbytes = flen + $urandom_range(1, 3);

            send_beat(start_beat(16'(flen), cap));
            repeat (nbytes) send_beat(data_beat(8'($urandom)));
            sent = sent + 1 + nbytes;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Directed special cases under the reset register values.
   task automatic test_special_cases;
      send_beat(data_beat(8'hFF));                           // byte with no frame: drop
      send_beat(start_beat(16'd0, 32'd0));                   // empty frame, first rebase
      send_beat(data_beat(8'h00));                           // nothing pending: drop
      send_beat(start_beat(16'(FRM_HDR), 32'hFFFF_FFFF));    // header-only frame
      repeat (FRM_HDR) send_beat(data_beat(8'($urandom)));   // all skipped
      send_beat(start_beat(16'(FRM_HDR + 2), 32'hFFFF_FFFF)); // zero capture delta
      repeat (FRM_HDR) send_beat(data_beat(8'($urandom)));
      send_beat(data_beat(8'h00));
      send_beat(data_beat(8'hFF));
      send_beat(data_beat(8'h5A));                           // beyond the frame: drop
      send_beat(start_beat(16'hFFFF, 32'd5));                // backward: rebase
      repeat (FRM_HDR + 1) send_beat(data_beat(8'($urandom)));
      // abandon the open packet mid-frame
      send_beat(start_beat(16'(FRM_HDR + 1), 32'h0000_1000));
      repeat (FRM_HDR + 1) send_beat(data_beat(8'($urandom)));
   endtask

   task automatic test_random_phase(input logic [6:0] pt, input logic [31:0] ssrc,
                                    input logic il, input int beats);
      set_config(pt, ssrc, il);
      send_random_frames(beats);
   endtask

   // Stall rsp long enough to fill the block while frames keep coming, then
   // pause the sender until the stream drains before offering more.
   task automatic test_backpressure;
      set_config(7'd0, 32'd0, 1'b0);
      rx_hold_left = 400;
      send_random_frames(60);
      wait_stream_drained();
      send_random_frames(20);
   endtask

   // Register values at their extremes on small frames: all ones without
   // interleave, then all zeros with interleave.
   task automatic test_register_extremes;
      set_config(7'h7F, 32'hFFFF_FFFF, 1'b0);
      gen_cap = gen_cap + 32'd160;
      send_beat(start_beat(16'(FRM_HDR + 6), gen_cap));
      repeat (FRM_HDR + 6) send_beat(data_beat(8'($urandom)));
      gen_cap = gen_cap + 32'd160;
      send_beat(start_beat(16'd0, gen_cap));

      set_config(7'd0, 32'd0, 1'b1);
      gen_cap = gen_cap + 32'd160;
      send_beat(start_beat(16'(FRM_HDR + 3), gen_cap));
      repeat (FRM_HDR + 3) send_beat(data_beat(8'($urandom)));
      gen_cap = gen_cap + 32'd160;
      send_beat(start_beat(16'(FRM_HDR), gen_cap));
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      // shadow starts from the reset state of the block
      csr_shadow.payload_type    = '0;
      csr_shadow.stream_ssrc     = '0;
      csr_shadow.tcp_interleaved = 1'b1;
      seq_num      = '0;
      prev_cap     = '0;
      prev_stime   = '0;
      cur_stime    = '0;
      payload_left = '0;
      fill_left    = '0;
      skip_left    = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      tx_idle_pct = 21;
      rx_idle_pct = 74;
      test_special_cases();
      test_random_phase(7'($urandom), $urandom, 1'b1, 65);

      // swap: sender idles heavily, receiver lightly
      tx_idle_pct = 74;
      rx_idle_pct = 21;
      test_backpressure();
      test_random_phase(7'd0, 32'd0, 1'b0, 65);

      // no idling on either side
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_register_extremes();
      test_random_phase(7'h7F, $urandom, 1'b1, 65);

      wait_stream_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("[rtp_audio_packetizer] OK");
      else
         $display("[rtp_audio_packetizer] ERROR");
      $finish;
   end

endmodule
